[hw/rtl/tmsd_pkg.sv]
//------------------------------------------------------------------------------
// tmsd_pkg
// Shared types and constants for the terminal mouse sequence decoder.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package tmsd_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;
  localparam int OUT_COORD_BITS = 16;

  localparam logic [7:0] ESC_CHAR   = 8'h1B;
  localparam logic [7:0] LBRK_CHAR  = 8'h5B;
  localparam logic [7:0] X10_CHAR   = 8'h4D;
  localparam logic [7:0] SGR_CHAR   = 8'h3C;
  localparam logic [7:0] SEMI_CHAR  = 8'h3B;
  localparam logic [7:0] PRESS_CHAR = 8'h4D;
  localparam logic [7:0] REL_CHAR   = 8'h6D;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] NINE_CHAR  = 8'h39;
  localparam logic [7:0] X10_OFFSET = 8'h20;

  localparam logic [31:0] CLICK_WINDOW_RESET = 32'd500000;
  localparam logic [0:0]  REG_CLICK_WINDOW   = 1'b0;

  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_X10  = 2'd1,
    FMT_SGR  = 2'd2,
    FMT_BAD  = 2'd3
  } fmt_t;

  localparam logic [2:0] EV_PRESS   = 3'd0;
  localparam logic [2:0] EV_RELEASE = 3'd1;
  localparam logic [2:0] EV_MOVE    = 3'd2;
  localparam logic [2:0] EV_DRAG    = 3'd3;
  localparam logic [2:0] EV_WHEEL   = 3'd4;

  localparam logic [2:0] BTN_NONE = 3'd0;
  localparam logic [2:0] BTN_WUP  = 3'd5;
  localparam logic [2:0] BTN_WDN  = 3'd6;
endpackage

[hw/rtl/tmsd_front.sv]
//------------------------------------------------------------------------------
// tmsd_front
// Takes report bytes, tracks the prefix and gathers raw or decimal fields.
// On the last byte it hands one finished report to the queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tmsd_front #(
  parameter int COORD_BITS = tmsd_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = tmsd_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           byte_in,
  input  logic                 last_byte,
  input  logic [TIME_BITS-1:0] now_us,
  output logic                 rep_valid,
  input  logic                 rep_ready,
  output logic                 rep_ok,
  output logic                 rep_x10,
  output logic                 rep_rel,
  output logic [15:0]          rep_bits,
  output logic [COORD_BITS-1:0] rep_x,
  output logic [COORD_BITS-1:0] rep_y,
  output logic [TIME_BITS-1:0] rep_now
);
  import tmsd_pkg::*;

  logic [3:0]            pos;
  fmt_t                  fmt;
  logic [7:0]            raw_b, raw_x, raw_y;
  logic [1:0]            fidx;
  logic [15:0]           dbtn;
  logic [COORD_BITS-1:0] dx, dy;
  logic                  term, rel, ferr;

  logic [3:0]            pos_next;
  fmt_t                  fmt_next;
  logic [7:0]            raw_b_next, raw_x_next, raw_y_next;
  logic [1:0]            fidx_next;
  logic [15:0]           dbtn_next;
  logic [COORD_BITS-1:0] dx_next, dy_next;
  logic                  term_next, rel_next, ferr_next;
  logic                  take;
  logic [3:0]            digit;

  assign in_ready = rep_ready;
  assign take     = in_valid && in_ready;
  assign digit    = 4'(byte_in - ZERO_CHAR);

  always_comb begin
    pos_next = (pos != 4'd15) ? pos + 4'd1 : pos;
    fmt_next = fmt;
    raw_b_next = raw_b; raw_x_next = raw_x; raw_y_next = raw_y;
    fidx_next = fidx; dbtn_next = dbtn; dx_next = dx; dy_next = dy;
    term_next = term; rel_next = rel; ferr_next = ferr;
    if (pos == 4'd0) begin
      if (byte_in != ESC_CHAR) fmt_next = FMT_BAD;
    end else if (pos == 4'd1) begin
      if (fmt != FMT_BAD && byte_in != LBRK_CHAR) fmt_next = FMT_BAD;
    end else if (pos == 4'd2) begin
      if (fmt == FMT_NONE) begin
        fmt_next = (byte_in == X10_CHAR) ? FMT_X10 :
                   (byte_in == SGR_CHAR) ? FMT_SGR : FMT_BAD;
      end
    end else if (fmt == FMT_X10) begin
      if (pos == 4'd3) raw_b_next = byte_in;
      else if (pos == 4'd4) raw_x_next = byte_in;
      else if (pos == 4'd5) raw_y_next = byte_in;
    end else if (fmt == FMT_SGR && !term && !ferr) begin
      if (byte_in >= ZERO_CHAR && byte_in <= NINE_CHAR) begin
        // shift-add times ten, one digit per item
        if (fidx == 2'd0)
          dbtn_next = (dbtn << 3) + (dbtn << 1) + 16'(digit);
        else if (fidx == 2'd1)
          dx_next = (dx << 3) + (dx << 1) + COORD_BITS'(digit);
        else
          dy_next = (dy << 3) + (dy << 1) + COORD_BITS'(digit);
      end else if (byte_in == SEMI_CHAR) begin
        if (fidx < 2'd2) fidx_next = fidx + 2'd1;
        else ferr_next = 1'b1;
      end else if (byte_in == PRESS_CHAR || byte_in == REL_CHAR) begin
        if (fidx == 2'd2) begin
          term_next = 1'b1;
          rel_next  = (byte_in == REL_CHAR);
        end else begin
          ferr_next = 1'b1;
        end
      end else begin
        ferr_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; fmt <= FMT_NONE; raw_b <= '0; raw_x <= '0; raw_y <= '0;
      fidx <= '0; dbtn <= '0; dx <= '0; dy <= '0;
      term <= 1'b0; rel <= 1'b0; ferr <= 1'b0;
    end else if (take) begin
      if (last_byte) begin
        pos <= '0; fmt <= FMT_NONE; raw_b <= '0; raw_x <= '0; raw_y <= '0;
        fidx <= '0; dbtn <= '0; dx <= '0; dy <= '0;
        term <= 1'b0; rel <= 1'b0; ferr <= 1'b0;
      end else begin
        pos <= pos_next; fmt <= fmt_next; raw_b <= raw_b_next;
        raw_x <= raw_x_next; raw_y <= raw_y_next; fidx <= fidx_next;
        dbtn <= dbtn_next; dx <= dx_next; dy <= dy_next;
        term <= term_next; rel <= rel_next; ferr <= ferr_next;
      end
    end
  end

  // final report uses the state as updated by the last item
  assign rep_valid = take && last_byte;
  assign rep_x10   = (fmt_next == FMT_X10);
  assign rep_ok    = (pos_next >= 4'd6) && (rep_x10 || (fmt_next == FMT_SGR &&
                     pos_next >= 4'd9 && term_next && !ferr_next));
  assign rep_rel   = rel_next;
  assign rep_bits  = rep_x10 ? {8'd0, 8'(raw_b_next - X10_OFFSET)} : dbtn_next;
  assign rep_x     = rep_x10 ? COORD_BITS'({{COORD_BITS{1'b0}}, raw_x_next})
                             - COORD_BITS'(33) : dx_next - COORD_BITS'(1);
  assign rep_y     = rep_x10 ? COORD_BITS'({{COORD_BITS{1'b0}}, raw_y_next})
                             - COORD_BITS'(33) : dy_next - COORD_BITS'(1);
  assign rep_now   = now_us;
endmodule

[hw/rtl/tmsd_queue.sv]
//------------------------------------------------------------------------------
// tmsd_queue
// Two-entry queue of finished reports between the front and back parts.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tmsd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [2];
  logic             wptr, rptr;
  logic [1:0]       count;
  logic             push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0; rptr <= 1'b0; count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !pop |=> count == 2'd2)
    else $error("queue count lost");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wptr == rptr)
    else $error("queue pointers disagree");
endmodule

[hw/rtl/tmsd_back.sv]
//------------------------------------------------------------------------------
// tmsd_back
// Turns a finished report into an event: held button, click run, totals.
// Output register decouples the receiver.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tmsd_back #(
  parameter int COORD_BITS = tmsd_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = tmsd_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [31:0]           click_window_us,
  input  logic                  rep_valid,
  output logic                  rep_ready,
  input  logic                  rep_ok,
  input  logic                  rep_x10,
  input  logic                  rep_rel,
  input  logic [15:0]           rep_bits,
  input  logic [COORD_BITS-1:0] rep_x,
  input  logic [COORD_BITS-1:0] rep_y,
  input  logic [TIME_BITS-1:0]  rep_now,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  status,
  output logic [2:0]            event_type,
  output logic [2:0]            button,
  output logic [15:0]           pos_x,
  output logic [15:0]           pos_y,
  output logic [2:0]            modifiers,
  output logic signed [1:0]     wheel_step,
  output logic                  click_second,
  output logic                  click_third,
  output logic [31:0]           valid_count,
  output logic [31:0]           invalid_count
);
  import tmsd_pkg::*;

  logic [2:0]           held;
  logic [TIME_BITS-1:0] last_press;
  logic [1:0]           run;
  logic [31:0]          vtot, itot;

  logic [2:0]           held_next, typ, btn;
  logic [1:0]           run_next, code;
  logic signed [1:0]    dlt;
  logic                 take;
  logic [TIME_BITS-1:0] diff;
  logic                 in_win;

  assign rep_ready = !out_valid || out_ready;
  assign take      = rep_valid && rep_ready;
  assign code      = rep_bits[1:0];
  assign diff      = rep_now - last_press;
  assign in_win    = (64'(diff) < 64'(click_window_us));

  always_comb begin
    held_next = held;
    dlt = 2'sd0;
    if (rep_bits[6]) begin
      typ = EV_WHEEL;
      btn = (code == 2'd0) ? BTN_WUP : BTN_WDN;
      dlt = (code == 2'd0) ? 2'sd1 : -2'sd1;
    end else if (rep_bits[5]) begin
      typ = (held != BTN_NONE) ? EV_DRAG : EV_MOVE;
      btn = held;
    end else if (rep_x10 ? (code == 2'd3) : rep_rel) begin
      typ = EV_RELEASE;
      btn = (rep_x10 || held != BTN_NONE) ? held : 3'(code) + 3'd1;
      held_next = BTN_NONE;
    end else begin
      typ = EV_PRESS;
      btn = 3'(code) + 3'd1;
      held_next = btn;
    end
    if (!in_win) run_next = 2'd1;
    else if (run != 2'd3) run_next = run + 2'd1;
    else run_next = run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= BTN_NONE; last_press <= '0; run <= '0; vtot <= '0; itot <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) begin
        out_valid <= 1'b1;
        if (!rep_ok) begin
          itot <= itot + 32'd1;
        end else begin
          vtot <= vtot + 32'd1;
          held <= held_next;
          if (typ == EV_PRESS) begin
            run <= run_next;
            last_press <= rep_now;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status        <= !rep_ok;
      event_type    <= rep_ok ? typ : EV_PRESS;
      button        <= rep_ok ? btn : BTN_NONE;
      pos_x         <= rep_ok ? 16'({{32{1'b0}}, rep_x}) : 16'd0;
      pos_y         <= rep_ok ? 16'({{32{1'b0}}, rep_y}) : 16'd0;
      modifiers     <= rep_ok ? rep_bits[4:2] : 3'd0;
      wheel_step    <= rep_ok ? dlt : 2'sd0;
      click_second  <= rep_ok && typ == EV_PRESS && run_next == 2'd2;
      click_third   <= rep_ok && typ == EV_PRESS && run_next == 2'd3;
      valid_count   <= rep_ok ? vtot + 32'd1 : vtot;
      invalid_count <= rep_ok ? itot : itot + 32'd1;
    end
  end

  a_one_total: assert property (@(posedge clk) disable iff (rst)
    take |=> (vtot + itot) == $past(vtot + itot) + 32'd1)
    else $error("totals did not advance by one");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(valid_count))
    else $error("result changed under stall");
  a_click_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(click_second && click_third))
    else $error("double and triple both set");
endmodule

[hw/rtl/terminal_mouse_sequence_decoder_unit.sv]
//------------------------------------------------------------------------------
// terminal_mouse_sequence_decoder_unit
// Decodes X10 and SGR terminal mouse reports into press, release, move,
// drag and wheel events with click counting.
//------------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one report byte per cycle with
//   last_byte and now_us. Each item marked last_byte yields exactly one
//   result on the output channel (out_valid/out_ready); other items yield
//   none. One byte per cycle is taken back to back while in_ready stays high.
//   Each finished report is written into the queue and then registered in
//   the back stage's output register.
//   The front gathers fields with one shift-add per byte; the back stage
//   applies held-button and click-window state, one report per cycle unless the receiver stalls.
//   A two-entry queue plus the output register let the input keep flowing
//   while the receiver stalls; when all are full in_ready drops.
//   click_window_us is written over the APB port at address 0; users must write it only while idle (not enforced).
//   Reset (rst, synchronous) clears all sequence state, the held button,
//   click run and totals, and sets the window to 500000 us.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module terminal_mouse_sequence_decoder_unit #(
  parameter int COORD_BITS = tmsd_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = tmsd_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           byte_in,
  input  logic                 last_byte,
  input  logic [31:0]          now_us,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 status,
  output logic [2:0]           event_type,
  output logic [2:0]           button,
  output logic [15:0]          pos_x,
  output logic [15:0]          pos_y,
  output logic [2:0]           modifiers,
  output logic signed [1:0]    wheel_step,
  output logic                 click_second,
  output logic                 click_third,
  output logic [31:0]          valid_count,
  output logic [31:0]          invalid_count
);
  import tmsd_pkg::*;

  localparam int QW = 3 + 16 + 2 * COORD_BITS + TIME_BITS;

  logic [31:0]           click_window_us;
  logic [TIME_BITS-1:0]  now_t;
  logic                  f_valid, f_ready, q_valid, q_ready;
  logic                  f_ok, f_x10, f_rel, q_ok, q_x10, q_rel;
  logic [15:0]           f_bits, q_bits;
  logic [COORD_BITS-1:0] f_x, f_y, q_x, q_y;
  logic [TIME_BITS-1:0]  f_now, q_now;

  assign pready = 1'b1;
  // register index sits above the byte lane bits
  assign prdata = (paddr[2] == REG_CLICK_WINDOW) ? click_window_us : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      click_window_us <= CLICK_WINDOW_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CLICK_WINDOW) begin
      click_window_us <= pwdata;
    end
  end

  assign now_t = TIME_BITS'({{32{1'b0}}, now_us});

  tmsd_front #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .byte_in, .last_byte, .now_us(now_t),
    .rep_valid(f_valid), .rep_ready(f_ready), .rep_ok(f_ok), .rep_x10(f_x10),
    .rep_rel(f_rel), .rep_bits(f_bits), .rep_x(f_x), .rep_y(f_y),
    .rep_now(f_now)
  );

  tmsd_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data({f_ok, f_x10, f_rel, f_bits, f_x, f_y, f_now}),
    .rd_valid(q_valid), .rd_ready(q_ready),
    .rd_data({q_ok, q_x10, q_rel, q_bits, q_x, q_y, q_now})
  );

  tmsd_back #(.COORD_BITS(COORD_BITS), .TIME_BITS(TIME_BITS)) u_back (
    .clk, .rst, .click_window_us,
    .rep_valid(q_valid), .rep_ready(q_ready), .rep_ok(q_ok), .rep_x10(q_x10),
    .rep_rel(q_rel), .rep_bits(q_bits), .rep_x(q_x), .rep_y(q_y),
    .rep_now(q_now),
    .out_valid, .out_ready, .status, .event_type, .button, .pos_x, .pos_y,
    .modifiers, .wheel_step, .click_second, .click_third,
    .valid_count, .invalid_count
  );
endmodule

[tb/terminal_mouse_sequence_decoder_unit_tb.sv]
//------------------------------------------------------------------------------
// terminal_mouse_sequence_decoder_unit_tb
// Feeds X10 and SGR mouse reports (well formed, broken and noise) byte by byte
// under several idle and stall patterns, predicts every event in a behavioral
// decoder and compares each field of each result in arrival order.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module terminal_mouse_sequence_decoder_unit_tb;
  import tmsd_pkg::*;

  typedef struct packed {
    logic        status;
    logic [2:0]  event_type;
    logic [2:0]  button;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [2:0]  modifiers;
    logic [1:0]  wheel_step;
    logic        click_second;
    logic        click_third;
    logic [31:0] valid_count;
    logic [31:0] invalid_count;
  } mouse_event_t;

  localparam int  CYCLE_LIMIT = 400000;
  localparam logic [2:0] ADDR_CLICK_WINDOW = {REG_CLICK_WINDOW, 2'b00};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] byte_in = '0;
  logic last_byte = 1'b0;
  logic [31:0] now_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mouse_event_t got;

  always #10 clk = ~clk;

  terminal_mouse_sequence_decoder_unit DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .byte_in(byte_in), .last_byte(last_byte), .now_us(now_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(got.status), .event_type(got.event_type), .button(got.button),
    .pos_x(got.pos_x), .pos_y(got.pos_y), .modifiers(got.modifiers),
    .wheel_step(got.wheel_step), .click_second(got.click_second),
    .click_third(got.click_third), .valid_count(got.valid_count),
    .invalid_count(got.invalid_count)
  );

  // predictor state
  logic [31:0] window_us;
  logic [3:0]  seq_pos;
  fmt_t        seq_fmt;
  logic [7:0]  x10_btn, x10_x, x10_y;
  logic [1:0]  field_idx;
  logic [15:0] dec_btn, dec_x, dec_y;
  logic        term_seen, rel_seen, sgr_err;
  logic [2:0]  held;
  logic [31:0] press_time;
  logic [1:0]  run_len;
  logic [31:0] good_total, bad_total;

  mouse_event_t pending_events[$];
  int   fail_count = 0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic [31:0] clock_us = 32'd1000;

  function automatic void clear_report();
    seq_pos = '0; seq_fmt = FMT_NONE;
    x10_btn = '0; x10_x = '0; x10_y = '0;
    field_idx = '0; dec_btn = '0; dec_x = '0; dec_y = '0;
    term_seen = 1'b0; rel_seen = 1'b0; sgr_err = 1'b0;
  endfunction

  function automatic void sgr_char(input logic [7:0] b);
    if (term_seen || sgr_err) return;
    if (b >= ZERO_CHAR && b <= NINE_CHAR) begin
      case (field_idx)
        2'd0: dec_btn = dec_btn * 16'd10 + 16'(b - ZERO_CHAR);
        2'd1: dec_x = dec_x * 16'd10 + 16'(b - ZERO_CHAR);
        default: dec_y = dec_y * 16'd10 + 16'(b - ZERO_CHAR);
      endcase
    end else if (b == SEMI_CHAR) begin
      if (field_idx < 2) field_idx++;
      else sgr_err = 1'b1;
    end else if (b == PRESS_CHAR || b == REL_CHAR) begin
      if (field_idx == 2) begin
        term_seen = 1'b1;
        rel_seen = (b == REL_CHAR);
      end else begin
        sgr_err = 1'b1;
      end
    end else begin
      sgr_err = 1'b1;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic lst,
                                      input logic [31:0] t);
    mouse_event_t e;
    logic [7:0]  bits;
    logic [15:0] bits16;
    logic [1:0]  code;
    logic        is_x10, ok;
    case (seq_pos)
      4'd0: if (b != ESC_CHAR) seq_fmt = FMT_BAD;
      4'd1: if (seq_fmt != FMT_BAD && b != LBRK_CHAR) seq_fmt = FMT_BAD;
      4'd2: if (seq_fmt == FMT_NONE)
              seq_fmt = (b == X10_CHAR) ? FMT_X10 : (b == SGR_CHAR) ? FMT_SGR : FMT_BAD;
      default: begin
        if (seq_fmt == FMT_X10) begin
          if (seq_pos == 3) x10_btn = b;
          else if (seq_pos == 4) x10_x = b;
          else if (seq_pos == 5) x10_y = b;
        end else if (seq_fmt == FMT_SGR) begin
          sgr_char(b);
        end
      end
    endcase
    if (seq_pos < 15) seq_pos++;
    if (!lst) return;

    e = '0;
    is_x10 = (seq_fmt == FMT_X10);
    ok = (seq_pos >= 6) && (is_x10 || (seq_fmt == FMT_SGR && seq_pos >= 9 &&
                                       term_seen && !sgr_err));
    if (!ok) begin
      bad_total++;
      e.status = 1'b1;
    end else begin
      if (is_x10) begin
        bits16 = {8'h00, 8'(x10_btn - X10_OFFSET)};
        e.pos_x = {8'h00, x10_x} - 16'd33;
        e.pos_y = {8'h00, x10_y} - 16'd33;
      end else begin
        bits16 = dec_btn;
        e.pos_x = dec_x - 16'd1;
        e.pos_y = dec_y - 16'd1;
      end
      bits = bits16[7:0];
      code = bits[1:0];
      if (bits[6]) begin
        e.event_type = EV_WHEEL;
        e.button = (code == 0) ? BTN_WUP : BTN_WDN;
        e.wheel_step = (code == 0) ? 2'sd1 : -2'sd1;
      end else if (bits[5]) begin
        e.event_type = (held != BTN_NONE) ? EV_DRAG : EV_MOVE;
        e.button = held;
      end else if (is_x10 ? (code == 3) : rel_seen) begin
        e.event_type = EV_RELEASE;
        e.button = (is_x10 || held != BTN_NONE) ? held : 3'(code) + 3'd1;
        held = BTN_NONE;
      end else begin
        e.event_type = EV_PRESS;
        e.button = 3'(code) + 3'd1;
        held = e.button;
        if (t - press_time < window_us) begin
          if (run_len < 3) run_len++;
        end else begin
          run_len = 2'd1;
        end
        press_time = t;
        e.click_second = (run_len == 2);
        e.click_third = (run_len == 3);
      end
      e.modifiers = bits[4:2];
      good_total++;
    end
    e.valid_count = good_total;
    e.invalid_count = bad_total;
    pending_events.push_back(e);
    clear_report();
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    mouse_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          if (got.event_type !== want.event_type)
            $display("%0t: event_type expected %0d actual %0d", $time,
                     want.event_type, got.event_type);
          if (got.button !== want.button)
            $display("%0t: button expected %0d actual %0d", $time, want.button, got.button);
          if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y)
            $display("%0t: pos expected %0d,%0d actual %0d,%0d", $time,
                     want.pos_x, want.pos_y, got.pos_x, got.pos_y);
          if (got.valid_count !== want.valid_count ||
              got.invalid_count !== want.invalid_count)
            $display("%0t: counts expected %0d/%0d actual %0d/%0d", $time,
                     want.valid_count, want.invalid_count,
                     got.valid_count, got.invalid_count);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays up between items unless the sender idles
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    last_byte <= lst;
    now_us <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, lst, t);
    @(negedge clk);
  endtask

  task automatic send_report(input logic [7:0] bytes[$], input logic [31:0] t);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, t);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_window(input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_CLICK_WINDOW; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    window_us = value;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic void append_dec(ref logic [7:0] q[$], input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    foreach (s[i]) q.push_back(s[i]);
  endfunction

  task automatic send_x10(input logic [7:0] b, x, y, input logic [31:0] t);
    logic [7:0] q[$];
    q = '{ESC_CHAR, LBRK_CHAR, X10_CHAR, b, x, y};
    send_report(q, t);
  endtask

  task automatic send_sgr(input int unsigned b, x, y, input logic rel,
                          input logic [31:0] t);
    logic [7:0] q[$];
    q = '{ESC_CHAR, LBRK_CHAR, SGR_CHAR};
    append_dec(q, b); q.push_back(SEMI_CHAR);
    append_dec(q, x); q.push_back(SEMI_CHAR);
    append_dec(q, y); q.push_back(rel ? REL_CHAR : PRESS_CHAR);
    send_report(q, t);
  endtask

  task automatic test_directed();
    logic [7:0] q[$];
    send_x10(8'h20, 8'h21, 8'h21, 32'd100);        // left press at origin
    send_x10(8'h20, 8'h30, 8'h31, 32'd200);        // double click
    send_x10(8'h3C, 8'hFF, 8'hFF, 32'd300);        // triple, all modifiers
    send_x10(8'h40, 8'h00, 8'h00, 32'd400);        // drag, coords below offset
    send_x10(8'h23, 8'h22, 8'h22, 32'd500);        // release
    send_x10(8'h23, 8'h22, 8'h22, 32'd600);        // release with nothing held
    send_x10(8'h60, 8'h25, 8'h25, 32'd700);        // wheel up
    send_x10(8'h61, 8'h25, 8'h25, 32'd800);        // wheel down
    send_x10(8'h00, 8'h7F, 8'h80, 32'd900);        // button byte below offset
    send_x10(8'h42, 8'h21, 8'h21, 32'd950);        // move, nothing held
    send_sgr(2, 1, 1, 1'b1, 32'd1000);             // release without hold
    send_sgr(0, 0, 0, 1'b0, 32'hFFFF_FFF0);        // zero coords wrap
    send_sgr(99999, 123456, 65536, 1'b0, 32'd5);   // decimal wrap
    send_sgr(32, 10, 10, 1'b0, 32'd6);
    send_sgr(0, 1, 1, 1'b1, 32'd7);
    q = '{ESC_CHAR, LBRK_CHAR, X10_CHAR, 8'h20, 8'h21}; send_report(q, 32'd8);
    q = '{ESC_CHAR, LBRK_CHAR, SGR_CHAR, "1", ";", "2", "M"}; send_report(q, 32'd9);
    q = '{ESC_CHAR, 8'h5A, X10_CHAR, 8'h20, 8'h21, 8'h21}; send_report(q, 32'd10);
    q = '{ESC_CHAR, LBRK_CHAR, SGR_CHAR, "1", ";", "2", ";", "3", ";", "4", "M"};
    send_report(q, 32'd11);
    q = '{ESC_CHAR, LBRK_CHAR, SGR_CHAR, "1", ";", "2", "x", "3", "M"};
    send_report(q, 32'd12);
    q = '{ESC_CHAR, LBRK_CHAR, SGR_CHAR, "1", ";", "2", ";", "3", "3"};
    send_report(q, 32'd13);
    q = '{ESC_CHAR, LBRK_CHAR, SGR_CHAR, "1", ";", "2", ";", "3", "m", "Z", 8'hFF};
    send_report(q, 32'd14);
    q = '{ESC_CHAR, LBRK_CHAR, X10_CHAR, 8'h21, 8'h21, 8'h21, 8'h00, 8'hFF, 8'h55, 8'hAA,
          8'h11, 8'h22, 8'h33, 8'h44, 8'h66, 8'h77, 8'h88};
    send_report(q, 32'd15);
    q = '{8'hFF}; send_report(q, 32'd16);
    wait_drained();
  endtask

  task automatic random_report();
    logic [7:0] q[$];
    int kind;
    int n;
    string picks = "0;Mm9";
    kind = $urandom_range(9);
    clock_us += (($urandom_range(3) == 0) ? $urandom : $urandom_range(window_us / 2 + 1));
    if (kind < 4) begin
      send_x10(8'($urandom_range(3) == 0 ? $urandom : 32 + $urandom_range(99)),
               8'($urandom), 8'($urandom), clock_us);
    end else if (kind < 8) begin
      send_sgr($urandom_range(3) == 0 ? $urandom_range(99999) : $urandom_range(127),
               $urandom_range(3) == 0 ? $urandom_range(999999) : $urandom_range(300),
               $urandom_range(3) == 0 ? $urandom_range(999999) : $urandom_range(300),
               1'($urandom), clock_us);
    end else if (kind == 8) begin
      // broken: mostly a good prefix, then random bytes
      q = '{ESC_CHAR, LBRK_CHAR, $urandom_range(1) ? SGR_CHAR : X10_CHAR};
      if ($urandom_range(3) == 0) q[$urandom_range(2)] = 8'($urandom);
      n = $urandom_range(8);
      repeat (n) q.push_back($urandom_range(1) ? 8'($urandom) : 8'(picks[$urandom_range(4)]));
      send_report(q, clock_us);
    end else begin
      n = 1 + $urandom_range(17);
      repeat (n) q.push_back(8'($urandom));
      send_report(q, clock_us);
    end
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input int reports, input logic [31:0] window);
    write_window(window);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (reports) random_report();
    wait_drained();
  endtask

  task automatic test_drain_pause();
    send_x10(8'h21, 8'h40, 8'h40, clock_us);
    wait_drained();
    send_sgr(1, 40, 40, 1'b1, clock_us + 1);
    wait_drained();
  endtask

  initial begin
    window_us = CLICK_WINDOW_RESET;
    clear_report();
    held = BTN_NONE;
    press_time = '0;
    run_len = '0;
    good_total = '0;
    bad_total = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_phase(0, 0, 6, 32'd0);
    test_random_phase(52, 0, 6, 32'hFFFF_FFFF);
    test_random_phase(0, 52, 6, 32'd1000);
    test_random_phase(8, 8, 6, 32'd500000);
    test_drain_pause();
    test_random_phase(0, 0, 3, 32'h8000_0000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
